[sv/cdq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_pkg
// shared types and constants of the circular deque unit
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int DATA_W   = 32;
  localparam int CAP_W    = 7;
  localparam int FUNC_W   = 2;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;
  localparam int OUT_DW   = 80;

  localparam logic [CAP_W-1:0]  CAP_RESET = 7'd64;
  localparam logic [APB_AW-1:0] ADDR_CAPACITY = 3'd0;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH_FRONT = 2'd0,
    FUNC_PUSH_REAR  = 2'd1,
    FUNC_POP_FRONT  = 2'd2,
    FUNC_POP_REAR   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_LOAD = 3'b100
  } state_t;

endpackage
`default_nettype wire

[sv/cdq_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_store
// entry memory: one write port, two registered read ports
// ----------------------------------------------------------------------------
module cdq_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [AW-1:0]              waddr,
  input  wire logic [cdq_pkg::DATA_W-1:0] wdata,
  input  wire logic                       re,
  input  wire logic [AW-1:0]              raddr_a,
  input  wire logic [AW-1:0]              raddr_b,
  output      logic [cdq_pkg::DATA_W-1:0] rdata_a,
  output      logic [cdq_pkg::DATA_W-1:0] rdata_b
);
  import cdq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire

[sv/circular_deque_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// circular_deque_unit
// double-ended queue in a circular entry memory with apb capacity register
// ----------------------------------------------------------------------------
// Each word on the input stream is one operation (tuser: push front, push
// rear, pop front, pop rear; tdata: value pushed). The indices, count and
// entry write are updated at the edge that accepts the word, the new front
// and rear entries are read from the two-port memory in the next cycle, and
// the result is loaded into the output register in the load state, which
// waits while an earlier result is unread; a new word is accepted only after
// that load, as the write-then-read sequence runs through the registered
// memory. The output register lets the next word be accepted while a result
// still waits on the master side. A push while full or a pop while empty
// leaves the queue unchanged and sets the ignored flag. Capacity 0 acts as 1,
// values above DEPTH act as DEPTH. The memory needs no clearing after reset.
// ----------------------------------------------------------------------------
module circular_deque_unit #(
  parameter int DEPTH = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // s_tdata: data[31:0]
  input  wire logic [cdq_pkg::DATA_W-1:0] s_tdata,
  // s_tuser: func[1:0]
  input  wire logic [cdq_pkg::FUNC_W-1:0] s_tuser,
  input  wire logic                       s_tvalid,
  output      logic                       s_tready,
  // m_tdata: front_value[31:0], rear_value[63:32], count[70:64],
  // is_empty[71], is_full[72], ignored[73], zero[79:74]
  output      logic [cdq_pkg::OUT_DW-1:0] m_tdata,
  output      logic                       m_tvalid,
  input  wire logic                       m_tready,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [cdq_pkg::APB_AW-1:0] paddr,
  input  wire logic [cdq_pkg::APB_DW-1:0] pwdata,
  output      logic [cdq_pkg::APB_DW-1:0] prdata,
  output      logic                       pready
);
  import cdq_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW = ((IW > CAP_W) ? IW : CAP_W) + 1;
  localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

  state_t            state, state_next;
  logic [CAP_W-1:0]  capacity;
  logic [IW-1:0]     head, head_next;
  logic [IW-1:0]     tail, tail_next;
  logic [CAP_W-1:0]  held, held_next;
  logic              res_ignored;
  logic              res_full;
  logic [DATA_W-1:0] rd_front, rd_rear;
  logic              out_valid;
  logic [OUT_DW-1:0] out_data;

  logic              accept, out_take, load;
  logic [XW-1:0]     cap_x, held_x;
  logic              full_now, empty_now, ignored_now;
  logic              we;
  logic [IW-1:0]     waddr;
  func_t             func;

  function automatic logic [IW-1:0] step_fwd(logic [IW-1:0] idx, logic [XW-1:0] cap);
    logic [XW-1:0] nxt;
    nxt = XW'(idx) + XW'(1);
    return (nxt >= cap) ? '0 : nxt[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] step_back(logic [IW-1:0] idx, logic [XW-1:0] cap);
    logic [XW-1:0] last;
    last = cap - XW'(1);
    return (idx == '0 || XW'(idx) >= cap) ? last[IW-1:0] : idx - IW'(1);
  endfunction

  // apb register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_CAPACITY) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_CAPACITY) begin
      prdata = APB_DW'(capacity);
    end
  end

  // operation
  assign func      = func_t'(s_tuser);
  assign s_tready  = (state == S_IDLE) && !rst;
  assign accept    = s_tvalid && s_tready;
  assign out_take  = out_valid && m_tready;
  assign load      = (state == S_LOAD) && (!out_valid || m_tready);

  always_comb begin
    if (capacity == '0) begin
      cap_x = XW'(1);
    end else if (XW'(capacity) > DEPTH_X) begin
      cap_x = DEPTH_X;
    end else begin
      cap_x = XW'(capacity);
    end
  end

  assign held_x    = XW'(held);
  assign full_now  = held_x >= cap_x;
  assign empty_now = (held == '0);

  always_comb begin
    head_next   = head;
    tail_next   = tail;
    held_next   = held;
    ignored_now = 1'b0;
    we          = 1'b0;
    waddr       = head;
    case (func)
      FUNC_PUSH_FRONT, FUNC_PUSH_REAR: begin
        if (full_now) begin
          ignored_now = 1'b1;
        end else begin
          we        = 1'b1;
          held_next = held + CAP_W'(1);
          if (empty_now) begin
            head_next = '0;
            tail_next = '0;
            waddr     = '0;
          end else if (func == FUNC_PUSH_FRONT) begin
            head_next = step_back(head, cap_x);
            waddr     = head_next;
          end else begin
            tail_next = step_fwd(tail, cap_x);
            waddr     = tail_next;
          end
        end
      end
      FUNC_POP_FRONT, FUNC_POP_REAR: begin
        if (empty_now) begin
          ignored_now = 1'b1;
        end else begin
          held_next = held - CAP_W'(1);
          if (held_next == '0) begin
            head_next = '0;
            tail_next = '0;
          end else if (func == FUNC_POP_FRONT) begin
            head_next = step_fwd(head, cap_x);
          end else begin
            tail_next = step_back(tail, cap_x);
          end
        end
      end
      default: begin
        ignored_now = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_READ;
      S_READ:  state_next = S_LOAD;
      S_LOAD:  if (load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
      held  <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        head <= head_next;
        tail <= tail_next;
        held <= held_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_ignored <= ignored_now;
      res_full    <= XW'(held_next) >= cap_x;
    end
  end

  cdq_store #(
    .DEPTH (DEPTH),
    .AW    (IW)
  ) u_store (
    .clk     (clk),
    .we      (accept && we),
    .waddr   (waddr),
    .wdata   (s_tdata),
    .re      (state == S_READ),
    .raddr_a (head),
    .raddr_b (tail),
    .rdata_a (rd_front),
    .rdata_b (rd_rear)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= {6'd0, res_ignored, res_full, (held == '0), held,
                   (held == '0) ? '0 : rd_rear,
                   (held == '0) ? '0 : rd_front};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  a_accept_reads : assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_READ)
    else $error("accepted word not followed by memory read");

  a_read_loads : assert property (@(posedge clk) disable iff (rst)
    state == S_READ |=> state == S_LOAD)
    else $error("memory read not followed by load");

  a_empty_indices : assert property (@(posedge clk) disable iff (rst)
    held == '0 |-> head == '0 && tail == '0)
    else $error("empty queue with indices off zero");

  a_empty_result : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data[71] |-> out_data[70:0] == '0)
    else $error("empty result with nonzero values or count");

  a_hold_output : assert property (@(posedge clk) disable iff (rst)
    state == S_LOAD && out_valid && !m_tready |=> state == S_LOAD)
    else $error("result dropped while output stalled");

endmodule
`default_nettype wire
